FILE: design/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Types, codes and helpers shared by the LIKE pattern matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpm_pkg;

   localparam int CP_W = 21;
   localparam int MAX_PATTERN_ELEMENTS = 64;

   localparam logic [CP_W-1:0] CP_PERCENT    = 21'h00025;
   localparam logic [CP_W-1:0] CP_UNDERSCORE = 21'h0005F;
   localparam logic [CP_W-1:0] CP_BACKSLASH  = 21'h0005C;
   localparam logic [CP_W-1:0] CP_UPPER_A    = 21'h00041;
   localparam logic [CP_W-1:0] CP_UPPER_Z    = 21'h0005A;
   localparam logic [CP_W-1:0] CP_CASE_BIT   = 21'h00020;

   // csr map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_WORD_CASE_INSENSITIVE = 1'b0;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2,
      OP_END     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_ONE     = 2'd1,
      KIND_RUN     = 2'd2
   } kind_type;

   // new pattern element, broadcast to the row
   typedef struct packed {
      logic            en;
      kind_type        kind;
      logic [CP_W-1:0] ch;
   } load_type;

   // text step control, broadcast to the row
   typedef struct packed {
      logic            rearm;
      logic            text_en;
      logic            nocase;
      logic [CP_W-1:0] text_ch;
   } step_type;

   // ascii-only case folding
   function automatic logic [CP_W-1:0] fold_cp(input logic [CP_W-1:0] c, input logic nocase);
      logic [CP_W-1:0] r;
      r = c;
      if (nocase && (c inside {[CP_UPPER_A:CP_UPPER_Z]})) begin
         r = c | CP_CASE_BIT;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/lpm_cell.sv
// ----------------------------------------------------------------------------
// lpm_cell
// One pattern element and the active bit of the position in front of it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [CNT_W-1:0]        count,
   input  lpm_pkg::load_type       load,
   input  lpm_pkg::step_type       step,
   input  wire                     closed_act,
   input  wire                     adv_prev,
   output logic                    act_raw,
   output logic                    is_run,
   output logic                    adv
);

   logic [lpm_pkg::CP_W-1:0] ch_ff;
   lpm_pkg::kind_type        kind_ff;
   logic                     act_ff;
   logic                     act_in;
   logic                     valid;
   logic                     lit_hit;
   logic                     stay;

   assign valid   = count > CNT_W'(INDEX);
   assign is_run  = valid && (kind_ff == lpm_pkg::KIND_RUN);
   assign lit_hit = lpm_pkg::fold_cp(ch_ff, step.nocase) == step.text_ch;

   always_comb begin
      stay = closed_act && is_run;
      adv  = 1'b0;
      if (closed_act && valid) begin
         case (kind_ff)
            lpm_pkg::KIND_ONE:     adv = 1'b1;
            lpm_pkg::KIND_LITERAL: adv = lit_hit;
            default:               adv = 1'b0;
         endcase
      end
   end

   always_comb begin
      act_in = act_ff;
      if (step.rearm) begin
         act_in = (INDEX == 0);
      end else if (step.text_en) begin
         act_in = stay || adv_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= (INDEX == 0);
      end else begin
         act_ff <= act_in;
      end
   end

   // element store, written once when the pattern grows to this slot
   always_ff @(posedge clock) begin
      if (load.en && count == CNT_W'(INDEX)) begin
         ch_ff   <= load.ch;
         kind_ff <= load.kind;
      end
   end

   assign act_raw = act_ff;

endmodule

`default_nettype wire

FILE: design/lpm_closure.sv
// ----------------------------------------------------------------------------
// lpm_closure
// Spreads active positions forward across '%' elements (parallel prefix).
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_closure #(
   parameter int NUM_POS = 65
) (
   input  wire  [NUM_POS-1:0] act_raw,
   input  wire  [NUM_POS-2:0] is_run,
   output logic [NUM_POS-1:0] act_closed
);

   localparam int LEVELS = (NUM_POS > 1) ? $clog2(NUM_POS) : 1;

   logic [NUM_POS-1:0] g [LEVELS+1];
   logic [NUM_POS-1:0] p [LEVELS+1];

   // position j is reached from j-1 when element j-1 is a run
   always_comb begin
      g[0] = act_raw;
      p[0] = {is_run, 1'b0};
      for (int lv = 0; lv < LEVELS; lv++) begin
         for (int j = 0; j < NUM_POS; j++) begin
            if (j >= (1 << lv)) begin
               g[lv+1][j] = g[lv][j] | (p[lv][j] & g[lv][j-(1<<lv)]);
               p[lv+1][j] = p[lv][j] & p[lv][j-(1<<lv)];
            end else begin
               g[lv+1][j] = g[lv][j];
               p[lv+1][j] = 1'b0;
            end
         end
      end
   end

   assign act_closed = g[LEVELS];

endmodule

`default_nettype wire

FILE: design/like_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// like_pattern_matcher_top
// SQL LIKE matcher: row of pattern cells tracking the active position set.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_operation, req_code_point
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_matched, rsp_pattern_overflow
//  csr     | in        | psel/penable/pready  | paddr, pwdata, pwrite, prdata
//
//  a text character goes through the whole cell row and the closure prefix
//  network in the cycle it is accepted
//  an end word puts its result in the rsp register the next cycle
//  req_stall only rises for an end word while an untaken result is held
//  reset rearms the active set and clears pattern length, flags and case setting
// ----------------------------------------------------------------------------
`default_nettype none

module like_pattern_matcher_top #(
   parameter int MAX_PATTERN_ELEMENTS = lpm_pkg::MAX_PATTERN_ELEMENTS
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [1:0]                        req_operation,
   input  wire  [lpm_pkg::CP_W-1:0]          req_code_point,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_matched,
   output logic                              rsp_pattern_overflow,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire  [lpm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire  [lpm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lpm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int N     = MAX_PATTERN_ELEMENTS;
   localparam int CNT_W = $clog2(N + 1);

   lpm_pkg::op_type   op;
   logic              accept;
   logic              nocase_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              esc_ff, esc_in;
   logic              ovf_ff, ovf_in;
   logic              act_last_ff, act_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              matched_ff, matched_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              append;
   lpm_pkg::load_type load;
   lpm_pkg::step_type step;
   logic [N:0]        act_raw;
   logic [N:0]        act_closed;
   logic [N-1:0]      is_run;
   logic [N-1:0]      adv;
   logic              csr_wr;
   logic              csr_hit;

   assign op        = lpm_pkg::op_type'(req_operation);
   assign req_stall = rsp_valid_ff && rsp_stall && (op == lpm_pkg::OP_END);
   assign accept    = req_valid && !req_stall;

   // ---------------- configuration ----------------
   assign pready  = 1'b1;
   assign csr_hit = paddr[lpm_pkg::CSR_ADDR_W-1:2] == lpm_pkg::CSR_WORD_CASE_INSENSITIVE;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign prdata  = csr_hit ? {{(lpm_pkg::CSR_DATA_W-1){1'b0}}, nocase_ff}
                            : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         nocase_ff <= 1'b0;
      end else if (csr_wr && csr_hit) begin
         nocase_ff <= pwdata[0];
      end
   end

   // ---------------- pattern loading ----------------
   always_comb begin
      load.en   = 1'b0;
      load.kind = lpm_pkg::KIND_LITERAL;
      load.ch   = req_code_point;
      esc_in    = esc_ff;
      if (accept && op == lpm_pkg::OP_PATTERN) begin
         if (esc_ff) begin
            esc_in  = 1'b0;
            load.en = 1'b1;
         end else if (req_code_point == lpm_pkg::CP_BACKSLASH) begin
            esc_in = 1'b1;
         end else begin
            load.en = 1'b1;
            if (req_code_point == lpm_pkg::CP_PERCENT) begin
               load.kind = lpm_pkg::KIND_RUN;
            end else if (req_code_point == lpm_pkg::CP_UNDERSCORE) begin
               load.kind = lpm_pkg::KIND_ONE;
            end
         end
      end
      if (accept && op == lpm_pkg::OP_START) begin
         esc_in = 1'b0;
      end
   end

   assign append = load.en && (count_ff < CNT_W'(N));

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept && op == lpm_pkg::OP_START) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (load.en) begin
         ovf_in = 1'b1;
      end
   end

   // ---------------- cell row ----------------
   always_comb begin
      step.rearm   = accept && (op inside {lpm_pkg::OP_START, lpm_pkg::OP_END});
      step.text_en = accept && (op == lpm_pkg::OP_TEXT);
      step.nocase  = nocase_ff;
      step.text_ch = lpm_pkg::fold_cp(req_code_point, nocase_ff);
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      lpm_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count_ff),
         .load       (load),
         .step       (step),
         .closed_act (act_closed[i]),
         .adv_prev   ((i == 0) ? 1'b0 : adv[(i == 0) ? 0 : i-1]),
         .act_raw    (act_raw[i]),
         .is_run     (is_run[i]),
         .adv        (adv[i])
      );
   end

   // position past the last element lives here
   assign act_raw[N] = act_last_ff;

   always_comb begin
      act_last_in = act_last_ff;
      if (step.rearm) begin
         act_last_in = 1'b0;
      end else if (step.text_en) begin
         act_last_in = adv[N-1];
      end
   end

   lpm_closure #(
      .NUM_POS (N + 1)
   ) u_closure (
      .act_raw    (act_raw),
      .is_run     (is_run),
      .act_closed (act_closed)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      matched_in   = matched_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept && op == lpm_pkg::OP_END) begin
         rsp_valid_in = 1'b1;
         matched_in   = !ovf_ff && !esc_ff && act_closed[count_ff];
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         esc_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         act_last_ff  <= (N == 0);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         esc_ff       <= esc_in;
         ovf_ff       <= ovf_in;
         act_last_ff  <= act_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   // ---------------- assertions ----------------
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(N))
      else $error("pattern length beyond store");

   a_ovf_full : assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == CNT_W'(N))
      else $error("overflow flagged with store not full");

   a_rearm : assert property (@(posedge clock) disable iff (reset)
      step.rearm |=> act_raw == {{N{1'b0}}, 1'b1})
      else $error("active set not rearmed to position zero");

   a_ovf_nomatch : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> !matched_ff)
      else $error("match reported with overflowed pattern");

endmodule

`default_nettype wire
